### rtl/masked_unique_pattern_scan_assert.svh
// Assertion macros used by the checker of the pattern scan.
`ifndef MASKED_UNIQUE_PATTERN_SCAN_ASSERT_SVH
`define MASKED_UNIQUE_PATTERN_SCAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MUPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MUPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mups_pkg.sv
package mups_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_PATTERN_BYTE = 2'd0,
      REQ_PATTERN_LEN  = 2'd1,
      REQ_DATA_BYTE    = 2'd2
   } mups_req_type;

   // Result outcomes carried in rsp_tuser
   typedef enum logic [1:0] {
      OUTCOME_UNIQUE     = 2'd0,
      OUTCOME_NOT_UNIQUE = 2'd1,
      OUTCOME_NONE       = 2'd2
   } mups_outcome_type;

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;
   localparam int OFFSET_OUT_BITS = 32;

   // Per-slot control for one accepted item
   typedef struct packed {
      logic       byte_we;
      logic       len_we;
      logic       data_step;
      logic       clear;
      logic [3:0] position;
      logic [7:0] pattern_byte;
      logic       must_match;
      logic [4:0] length;
   } mups_ctrl_type;

   typedef struct packed {
      mups_outcome_type             outcome;
      logic [1:0]                   pattern_number;
      logic [OFFSET_OUT_BITS-1:0]   match_offset;
   } mups_result_type;

endpackage

### rtl/mups_slot.sv
module mups_slot
   import mups_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = 16,
   parameter int OFFSET_BITS     = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mups_ctrl_type                    ctrl,
   input  logic [OFFSET_BITS-1:0]           here,
   input  logic [OFFSET_BITS-1:0]           seen_next,
   input  logic [MAX_PATTERN_LEN-1:0][7:0]  window,
   output logic [1:0]                       hits_step,
   output logic [OFFSET_BITS-1:0]           first_step
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN_LEN + 1);

   logic [7:0]                      pattern_ff [MAX_PATTERN_LEN];
   logic [MAX_PATTERN_LEN-1:0]      compare_ff;
   logic [LEN_BITS-1:0]             length_ff;
   logic [LEN_BITS-1:0]             length_in;
   logic [1:0]                      hits_ff;
   logic [1:0]                      hits_in;
   logic [OFFSET_BITS-1:0]          first_ff;
   logic [OFFSET_BITS-1:0]          first_in;
   logic [MAX_PATTERN_LEN-1:0][7:0] aligned;
   logic                            hit;

   // Clamp an oversized length to the table width
   always_comb begin
      if (int'(ctrl.length) > MAX_PATTERN_LEN) begin
         length_in = LEN_BITS'(MAX_PATTERN_LEN);
      end else begin
         length_in = LEN_BITS'(ctrl.length);
      end
   end

   // Pattern byte k lines up with window byte length-1-k
   always_comb begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
         aligned[k] = '0;
         for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (j == int'(length_ff) - 1 - k) begin
               aligned[k] = window[j];
            end
         end
      end
   end

   always_comb begin
      hit = (length_ff != '0) && (seen_next >= OFFSET_BITS'(length_ff));
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
         if ((k < int'(length_ff)) && compare_ff[k] && (pattern_ff[k] != aligned[k])) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      hits_step  = hits_ff;
      first_step = first_ff;
      if (ctrl.data_step && hit) begin
         if (hits_ff == 2'd0) begin
            first_step = here - OFFSET_BITS'(length_ff) + OFFSET_BITS'(1);
         end
         if (hits_ff != 2'd2) begin
            hits_step = hits_ff + 2'd1;
         end
      end
      hits_in  = ctrl.clear ? 2'd0 : hits_step;
      first_in = ctrl.clear ? '0 : first_step;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
         if (ctrl.byte_we && (int'(ctrl.position) == k)) begin
            pattern_ff[k] <= ctrl.pattern_byte;
            compare_ff[k] <= ctrl.must_match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         hits_ff   <= '0;
         first_ff  <= '0;
      end else begin
         if (ctrl.len_we) begin
            length_ff <= length_in;
         end
         hits_ff  <= hits_in;
         first_ff <= first_in;
      end
   end

endmodule

### rtl/masked_unique_pattern_scan.sv
// Channel   | Direction | Ports                         | Carries
// ----------+-----------+-------------------------------+-----------------------------------
// request   | in        | req_tvalid/tready/tdata/tuser | pattern loads and region bytes
//           |           | req_tlast                     | final byte of a region
// response  | out       | rsp_tvalid/tready/tdata/tuser | one scan result per region
// csr       | in        | csr_wr_en/csr_wr_data         | patterns_in_use register
//
// A new item is accepted each clock while req_tready is high.
// The result of a region appears on the response side the cycle after its last byte
// when the output register is free, otherwise once the result ahead of it is taken.
// Two result registers (output and skid) part the sides; req_tready drops only while
// both hold results nobody has taken.
// Reset is synchronous: it clears the window, byte counter, hit counts, lengths and
// the result valid flags; pattern bytes are kept undefined until written.
module masked_unique_pattern_scan
   import mups_pkg::*;
#(
   parameter int NUM_PATTERNS    = 4,
   parameter int MAX_PATTERN_LEN = 16,
   parameter int OFFSET_BITS     = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [1:0] pattern_index, [5:2] pattern_position, [13:6] pattern_byte,
   // [14] must_match, [19:15] pattern_length, [27:20] data_byte, rest zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]               req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [1:0] pattern_number, [33:2] match_offset, rest zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [1:0] outcome
   output logic [1:0]               rsp_tuser,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_wr_data
);

   logic [2:0]                      csr_ff;
   logic [MAX_PATTERN_LEN-1:0][7:0] window_ff;
   logic [MAX_PATTERN_LEN-1:0][7:0] window_in;
   logic [MAX_PATTERN_LEN-1:0][7:0] window_step;
   logic [OFFSET_BITS-1:0]          seen_ff;
   logic [OFFSET_BITS-1:0]          seen_next;
   logic [OFFSET_BITS-1:0]          seen_in;

   logic            req_fire;
   logic            rsp_fire;
   mups_req_type    req_kind;
   mups_ctrl_type   base_ctrl;
   mups_ctrl_type   slot_ctrl [NUM_PATTERNS];
   logic [1:0]      slot_hits [NUM_PATTERNS];
   logic [OFFSET_BITS-1:0] slot_first [NUM_PATTERNS];

   mups_result_type result;
   mups_result_type main_ff;
   mups_result_type main_in;
   mups_result_type skid_ff;
   mups_result_type skid_in;
   logic            main_valid_ff;
   logic            main_valid_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_kind   = mups_req_type'(req_tuser);

   // Decode the accepted item into slot controls
   always_comb begin
      base_ctrl              = '0;
      base_ctrl.position     = req_tdata[5:2];
      base_ctrl.pattern_byte = req_tdata[13:6];
      base_ctrl.must_match   = req_tdata[14];
      base_ctrl.length       = req_tdata[19:15];
      if (req_fire) begin
         unique case (req_kind)
            REQ_PATTERN_BYTE: base_ctrl.byte_we   = 1'b1;
            REQ_PATTERN_LEN:  base_ctrl.len_we    = 1'b1;
            REQ_DATA_BYTE: begin
               base_ctrl.data_step = 1'b1;
               base_ctrl.clear     = req_tlast;
            end
            default: ;
         endcase
      end
   end

   // Steer loads to the addressed slot; an index beyond the table hits nothing
   always_comb begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         slot_ctrl[p]         = base_ctrl;
         slot_ctrl[p].byte_we = base_ctrl.byte_we && (int'(req_tdata[1:0]) == p);
         slot_ctrl[p].len_we  = base_ctrl.len_we && (int'(req_tdata[1:0]) == p);
      end
   end

   // Shift the new byte in at the newest end, clearing on a region's last byte; hold the counter at its top value
   always_comb begin
      window_step[0] = req_tdata[27:20];
      for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
         window_step[i] = window_ff[i-1];
      end
      seen_next = (seen_ff != '1) ? seen_ff + OFFSET_BITS'(1) : seen_ff;
      window_in = window_ff;
      seen_in   = seen_ff;
      if (base_ctrl.data_step) begin
         window_in = base_ctrl.clear ? '0 : window_step;
         seen_in   = base_ctrl.clear ? '0 : seen_next;
      end
   end

   for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_slot
      mups_slot #(
         .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
         .OFFSET_BITS     (OFFSET_BITS)
      ) u_slot (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (slot_ctrl[p]),
         .here       (seen_ff),
         .seen_next  (seen_next),
         .window     (window_step),
         .hits_step  (slot_hits[p]),
         .first_step (slot_first[p])
      );
   end

   // Lowest tried slot with a hit decides; walk downwards so it wins
   always_comb begin
      result.outcome        = OUTCOME_NONE;
      result.pattern_number = '0;
      result.match_offset   = '0;
      for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
         if ((p < int'(csr_ff)) && (slot_hits[p] != 2'd0)) begin
            if (slot_hits[p] == 2'd1) begin
               result.outcome        = OUTCOME_UNIQUE;
               result.pattern_number = 2'(p);
               result.match_offset   = OFFSET_OUT_BITS'(slot_first[p]);
            end else begin
               result.outcome        = OUTCOME_NOT_UNIQUE;
               result.pattern_number = '0;
               result.match_offset   = '0;
            end
         end
      end
   end

   // Output register with a skid stage behind it
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         main_valid_in = (main_valid_ff && !rsp_fire) || base_ctrl.clear;
         if (base_ctrl.clear) begin
            if (main_valid_ff && !rsp_fire) begin
               skid_in       = result;
               skid_valid_in = 1'b1;
            end else begin
               main_in = result;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= '0;
         window_ff     <= '0;
         seen_ff       <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         window_ff     <= window_in;
         seen_ff       <= seen_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.outcome;
   assign rsp_tdata  = {6'b0, main_ff.match_offset, main_ff.pattern_number};

endmodule

### rtl/mups_checker.sv
`include "masked_unique_pattern_scan_assert.svh"

module mups_checker
   import mups_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [1:0]               req_tuser,
   input logic                     req_tlast,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [1:0]               rsp_tuser
);

   logic last_data_fire;

   assign last_data_fire = req_tvalid && req_tready && req_tlast
                           && (req_tuser == REQ_DATA_BYTE);

   // Stalled result holds its payload
   `MUPS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // A result that is not unique carries no pattern number or offset
   `MUPS_ASSERT_SAME(a_rsp_zero, rsp_tvalid && (rsp_tuser != OUTCOME_UNIQUE),
      rsp_tdata == '0, "non-unique result carries payload")

   // A fresh result follows an accepted last region byte
   `MUPS_ASSERT_SAME(a_rsp_cause, $rose(rsp_tvalid), $past(last_data_fire),
      "result without a last region byte")

   // Back-pressure only while a result is waiting
   `MUPS_ASSERT_SAME(a_ready_low, !req_tready, rsp_tvalid,
      "request stalled with no result pending")

endmodule

bind masked_unique_pattern_scan mups_checker u_checker (.*);
